[rtl/rpn_stack_calculator_macros.svh]
// Assertion macros shared by the calculator modules.
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RPNSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RPNSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rpnsc_pkg.sv]
// Package with codes, constants and the control interface types of the calculator.
package rpnsc_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int DATA_W          = 32;
  localparam int COUNT_OUT_W     = 11;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  // Request kinds.
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_OP   = 2'd1;
  localparam logic [1:0] REQ_POP  = 2'd2;

  // Operator codes; anything else is an unknown operator.
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input payload
    logic push_in;    // push the captured value
    logic pop_s;      // pop the top operand (read issue)
    logic pop_t;      // capture s, pop the second operand
    logic load_t;     // capture t
    logic pop_fin;    // finish a pop request
    logic nop_res;    // finish an unused request type
    logic mul;        // register the product
    logic div_start;  // launch the divider
    logic alu;        // finish an operator request
    logic emit;       // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

[rtl/rpnsc_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
`include "rpn_stack_calculator_macros.svh"

module rpnsc_ctrl
  import rpnsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [4:0] in_tuser,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PUSH   = 4'd1;
  localparam logic [3:0] S_POPS   = 4'd2;
  localparam logic [3:0] S_POPT   = 4'd3;
  localparam logic [3:0] S_POPFIN = 4'd4;
  localparam logic [3:0] S_OPLD   = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_DIVGO  = 4'd7;
  localparam logic [3:0] S_DIVW   = 4'd8;
  localparam logic [3:0] S_ALU    = 4'd9;
  localparam logic [3:0] S_NOP    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [1:0] req_r, req_nxt;
  logic [2:0] op_r, op_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       out_free;
  logic       accept;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    op_nxt         = op_r;
    out_tvalid_nxt = out_tvalid_r;
    cmd            = '0;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          req_nxt  = in_tuser[1:0];
          op_nxt   = in_tuser[4:2];
          unique case (in_tuser[1:0])
            REQ_PUSH: state_nxt = S_PUSH;
            REQ_OP:   state_nxt = S_POPS;
            REQ_POP:  state_nxt = S_POPS;
            default:  state_nxt = S_NOP;
          endcase
        end
      end
      S_PUSH: begin
        cmd.push_in = 1'b1;
        state_nxt   = S_DONE;
      end
      S_POPS: begin
        cmd.pop_s = 1'b1;
        state_nxt = (req_r == REQ_POP) ? S_POPFIN : S_POPT;
      end
      S_POPT: begin
        cmd.pop_t = 1'b1;
        state_nxt = S_OPLD;
      end
      S_POPFIN: begin
        cmd.pop_fin = 1'b1;
        state_nxt   = S_DONE;
      end
      S_OPLD: begin
        cmd.load_t = 1'b1;
        unique case (op_r)
          OP_MUL:  state_nxt = S_MUL;
          OP_DIV:  state_nxt = S_DIVGO;
          default: state_nxt = S_ALU;
        endcase
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ALU;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          state_nxt = S_ALU;
        end
      end
      S_ALU: begin
        cmd.alu   = 1'b1;
        state_nxt = S_DONE;
      end
      S_NOP: begin
        cmd.nop_res = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit       = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      req_r        <= REQ_PUSH;
      op_r         <= OP_ADD;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      req_r        <= req_nxt;
      op_r         <= op_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  `RPNSC_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != S_IDLE, "accepted request did not start")
  `RPNSC_ASSERT_NEXT(a_done_emits, (state_r == S_DONE) && out_free, out_tvalid_r && (state_r == S_IDLE), "finished result not presented")
  `RPNSC_ASSERT_IMPL(a_div_done_in_wait, sts.div_done, state_r == S_DIVW, "divider finished outside its wait state")

endmodule

[rtl/rpnsc_div.sv]
// Restoring divider for Q16.16 magnitudes: one quotient bit per cycle.
module rpnsc_div
  import rpnsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] num_mag,
  input  logic [DATA_W-1:0] den,
  output logic [DATA_W-1:0] quo,
  output logic              done
);

  localparam int STEP_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;

  // The dividend is num_mag shifted left by 16; the top 16 bits seed the remainder.
  always_comb begin
    shifted = {rem_r, quo_r[DATA_W-1]};
    trial   = shifted - {1'b0, den_r};
    if (!trial[DATA_W]) begin
      rem_nxt = trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {16'b0, num_mag[DATA_W-1:16]};
      quo_r <= {num_mag[15:0], 16'b0};
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

[rtl/rpnsc_dpath.sv]
// Datapath: stack memory, entry count, operand registers, arithmetic and output register.
`include "rpn_stack_calculator_macros.svh"

module rpnsc_dpath
  import rpnsc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [31:0] in_tdata,
  input  logic [4:0]  in_tuser,
  output logic [47:0] out_tdata,
  output logic [1:0]  out_tuser
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_r;

  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     cnt_m1;
  logic              full, empty_now;
  logic              s_hit_r, t_hit_r;
  logic [DATA_W-1:0] pv_r;
  logic [2:0]        op_r;
  logic [DATA_W-1:0] s_r, t_r;
  logic signed [63:0] prod_r;
  logic [DATA_W-1:0] res_r;
  logic [1:0]        stat_r;
  logic [DATA_W-1:0] out_res_r;
  logic [COUNT_OUT_W-1:0] out_count_r;
  logic [1:0]        out_stat_r;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;

  logic [DATA_W:0]   sum, diff;
  logic [DATA_W-1:0] t_mag, s_mag, quo;
  logic              div_neg, div_ovf, div_done;
  logic [DATA_W-1:0] alu_res;
  logic              alu_sat, alu_push;

  assign cnt_m1    = count_r - CW'(1);
  assign full      = (count_r == CW'(STACK_DEPTH));
  assign empty_now = (count_r == '0);
  assign raddr     = cnt_m1[AW-1:0];
  assign waddr     = count_r[AW-1:0];

  // Operator arithmetic, all results saturated to Q16.16.
  assign sum     = {t_r[DATA_W-1], t_r} + {s_r[DATA_W-1], s_r};
  assign diff    = {t_r[DATA_W-1], t_r} - {s_r[DATA_W-1], s_r};
  assign t_mag   = t_r[DATA_W-1] ? (~t_r + 32'd1) : t_r;
  assign s_mag   = s_r[DATA_W-1] ? (~s_r + 32'd1) : s_r;
  assign div_neg = t_r[DATA_W-1] ^ s_r[DATA_W-1];
  // Quotient of 2^32 or more when the high dividend half reaches the divisor.
  assign div_ovf = ({16'b0, t_mag[DATA_W-1:16]} >= s_mag);

  always_comb begin
    alu_res  = '0;
    alu_sat  = 1'b0;
    alu_push = 1'b1;
    unique case (op_r)
      OP_ADD: begin
        if (sum[DATA_W] != sum[DATA_W-1]) begin
          alu_sat = 1'b1;
          alu_res = sum[DATA_W] ? Q_MIN : Q_MAX;
        end else begin
          alu_res = sum[DATA_W-1:0];
        end
      end
      OP_SUB: begin
        if (diff[DATA_W] != diff[DATA_W-1]) begin
          alu_sat = 1'b1;
          alu_res = diff[DATA_W] ? Q_MIN : Q_MAX;
        end else begin
          alu_res = diff[DATA_W-1:0];
        end
      end
      OP_MUL: begin
        // The product shifted right by 16 fits when bits 63 down to 47 agree.
        if ((prod_r[63:47] != '0) && (prod_r[63:47] != '1)) begin
          alu_sat = 1'b1;
          alu_res = prod_r[63] ? Q_MIN : Q_MAX;
        end else begin
          alu_res = prod_r[47:16];
        end
      end
      OP_DIV: begin
        if (s_r == '0) begin
          alu_sat = 1'b1;
          if (t_r == '0) begin
            alu_res = '0;
          end else begin
            alu_res = t_r[DATA_W-1] ? Q_MIN : Q_MAX;
          end
        end else if (div_ovf) begin
          alu_sat = 1'b1;
          alu_res = div_neg ? Q_MIN : Q_MAX;
        end else if (!div_neg) begin
          if (quo[DATA_W-1]) begin
            alu_sat = 1'b1;
            alu_res = Q_MAX;
          end else begin
            alu_res = quo;
          end
        end else begin
          if (quo > Q_MIN) begin
            alu_sat = 1'b1;
            alu_res = Q_MIN;
          end else begin
            alu_res = ~quo + 32'd1;
          end
        end
      end
      default: alu_push = 1'b0;
    endcase
  end

  // Memory port control and count update.
  always_comb begin
    count_nxt = count_r;
    we        = 1'b0;
    re        = 1'b0;
    wdata     = pv_r;
    if (cmd.push_in && !full) begin
      we        = 1'b1;
      count_nxt = count_r + CW'(1);
    end
    if ((cmd.pop_s || cmd.pop_t) && !empty_now) begin
      re        = 1'b1;
      count_nxt = cnt_m1;
    end
    if (cmd.alu && alu_push) begin
      we        = 1'b1;
      wdata     = alu_res;
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pv_r <= in_tdata;
      op_r <= in_tuser[4:2];
    end
    if (cmd.pop_s) begin
      s_hit_r <= !empty_now;
    end
    if (cmd.pop_t) begin
      s_r     <= s_hit_r ? rdata_r : '0;
      t_hit_r <= !empty_now;
    end
    if (cmd.load_t) begin
      t_r <= t_hit_r ? rdata_r : '0;
    end
    if (cmd.mul) begin
      prod_r <= $signed(t_r) * $signed(s_r);
    end
    if (cmd.push_in) begin
      res_r  <= pv_r;
      stat_r <= full ? ST_FULL : ST_OK;
    end
    if (cmd.pop_fin) begin
      res_r  <= s_hit_r ? rdata_r : '0;
      stat_r <= s_hit_r ? ST_OK : ST_EMPTY;
    end
    if (cmd.nop_res) begin
      res_r  <= '0;
      stat_r <= ST_OK;
    end
    if (cmd.alu) begin
      res_r <= alu_push ? alu_res : '0;
      if (alu_sat) begin
        stat_r <= ST_SAT;
      end else if (!s_hit_r || !t_hit_r) begin
        stat_r <= ST_EMPTY;
      end else begin
        stat_r <= ST_OK;
      end
    end
    if (cmd.emit) begin
      out_res_r   <= res_r;
      out_count_r <= COUNT_OUT_W'(count_r);
      out_stat_r  <= stat_r;
    end
  end

  rpnsc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .num_mag (t_mag),
    .den     (s_mag),
    .quo     (quo),
    .done    (div_done)
  );

  assign sts.div_done = div_done;
  assign out_tdata    = {5'b0, out_count_r, out_res_r};
  assign out_tuser    = out_stat_r;

  `RPNSC_ASSERT_IMPL(a_count_in_range, 1'b1, count_r <= CW'(STACK_DEPTH), "entry count beyond depth")
  `RPNSC_ASSERT_NEXT(a_push_counts, cmd.push_in && !full, count_r == $past(count_r) + CW'(1), "push did not raise the count")
  `RPNSC_ASSERT_NEXT(a_empty_pop_miss, cmd.pop_s && empty_now, !s_hit_r && (count_r == '0), "pop of empty stack read an entry")

endmodule

[rtl/rpn_stack_calculator.sv]
// Top level of the reverse Polish calculator stack over signed Q16.16 values.
//
//   Channel  Direction  tdata (low bit first)                     tuser (low bit first)
//   in_      slave      push_value[31:0]                          req_type[1:0], operator_code[4:2]
//   out_     master     result_value[31:0], stack_count[42:32]    status[1:0]
//
// A request is taken only while the controller is idle; one request is worked at a time.
// Push, pop and the unused request type each pass through their own controller states;
// multiply adds a product state, and divide waits on the 32-step restoring divider.
// rst_n is synchronous and active low; it empties the stack (the memory is not cleared).
// A new request can be taken while the previous result still waits in the output register;
// a stalled output keeps the next finished result in the datapath while the controller
// waits in its done state.

module rpn_stack_calculator
  import rpnsc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // push_value
  input  logic [4:0]  in_tuser,   // req_type, operator_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // result_value, stack_count, zero fill
  output logic [1:0]  out_tuser   // status
);

  cmd_t cmd;
  sts_t sts;

  // The controller walks each request through its states and issues one command set per
  // cycle; the datapath owns the stack memory, the count and all arithmetic.
  rpnsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rpnsc_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
